// ===== src/count_pairs_within_radius_top_macros.svh =====
`ifndef COUNT_PAIRS_WITHIN_RADIUS_TOP_MACROS_SVH
`define COUNT_PAIRS_WITHIN_RADIUS_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CPWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition on the next edge follows a trigger.
`define CPWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cpwr_pkg.sv =====
package cpwr_pkg;

  localparam int unsigned PointW = 31;
  localparam int unsigned CountW = 19;
  localparam int unsigned RadiusW = 32;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [2:0] AddrRadius = 3'd0;

  typedef struct packed {
    logic [PointW-1:0] point;
    logic              last;
  } item_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INS    = 6'b000010,
    S_CNT_RD = 6'b000100,
    S_CNT_EV = 6'b001000,
    S_OUT    = 6'b010000,
    S_START  = 6'b100000
  } back_state_e;

endpackage

// ===== src/cpwr_front.sv =====
module cpwr_front
  import cpwr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [PointW-1:0] point_i,
  input  logic              last_i,
  output logic              q_valid_o,
  output item_t             q_item_o,
  input  logic              q_pop_i
);

  item_t      slot_q [2];
  logic       rd_q, rd_d;
  logic       wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rd_q];

  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = ~wr_q;
    end
    if (q_pop_i) begin
      rd_d = ~rd_q;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= '{point: point_i, last: last_i};
    end
  end

endmodule

// ===== src/cpwr_back.sv =====
module cpwr_back
  import cpwr_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [RadiusW-1:0] radius_i,
  input  logic               q_valid_i,
  input  item_t              q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CountW-1:0]  pair_count_o,
  output logic               overflow_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned SW = ((IW > CountW) ? IW : CountW) + 1;
  localparam logic [IW-1:0] Full = IW'(MAX_POINTS);

  logic [PointW-1:0] mem [MAX_POINTS];
  logic [PointW-1:0] rda_q, rdb_q;
  logic [IW-1:0]     ra, rb;
  logic              we;
  logic [IW-1:0]     wa;
  logic [PointW-1:0] wd;

  back_state_e       state_q, state_d;
  logic [IW-1:0]     fill_q, fill_d;
  logic              drop_q, drop_d;
  logic              last_q, last_d;
  logic [PointW-1:0] v_q, v_d;
  logic [IW-1:0]     j_q, j_d;
  logic [IW-1:0]     l_q, l_d;
  logic [IW-1:0]     r_q, r_d;
  logic [CountW-1:0] total_q, total_d;
  logic              ov_q, ov_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              oval_q, oval_d;

  logic [PointW-1:0] diff;
  logic [IW-1:0]     span;
  logic [SW-1:0]     sum;

  assign diff = rdb_q - rda_q;
  assign span = r_q - l_q;
  assign sum  = SW'(total_q) + SW'(span);

  assign out_valid_o  = oval_q;
  assign pair_count_o = cnt_q;
  assign overflow_o   = ov_q;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    drop_d  = drop_q;
    last_d  = last_q;
    v_d     = v_q;
    j_d     = j_q;
    l_d     = l_q;
    r_d     = r_q;
    total_d = total_q;
    ov_d    = ov_q;
    cnt_d   = cnt_q;
    oval_d  = oval_q && out_stall_i;
    q_pop_o = 1'b0;
    ra      = fill_q - IW'(1);
    rb      = r_q;
    we      = 1'b0;
    wa      = j_q;
    wd      = v_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          last_d  = q_item_i.last;
          if (fill_q != Full) begin
            v_d     = q_item_i.point;
            j_d     = fill_q;
            state_d = S_INS;
          end else begin
            drop_d = 1'b1;
            if (q_item_i.last) begin
              state_d = S_START;
            end
          end
        end
      end
      S_INS: begin
        // shift larger entries up one slot until v fits
        we = 1'b1;
        if (j_q != '0 && rda_q > v_q) begin
          wd  = rda_q;
          j_d = j_q - IW'(1);
          ra  = j_q - IW'(2);
        end else begin
          fill_d  = fill_q + IW'(1);
          state_d = last_q ? S_START : S_IDLE;
        end
      end
      S_START: begin
        l_d     = '0;
        r_d     = '0;
        total_d = '0;
        state_d = S_CNT_RD;
      end
      S_CNT_RD: begin
        ra = l_q;
        rb = r_q;
        state_d = (r_q == fill_q) ? S_OUT : S_CNT_EV;
      end
      S_CNT_EV: begin
        if (l_q != r_q && {1'b0, diff} >= radius_i) begin
          l_d = l_q + IW'(1);
        end else begin
          total_d = (sum > SW'(CountMax)) ? CountMax : sum[CountW-1:0];
          r_d     = r_q + IW'(1);
        end
        ra = l_d;
        rb = r_d;
        state_d = S_CNT_RD;
      end
      S_OUT: begin
        if (!oval_q || !out_stall_i) begin
          oval_d  = 1'b1;
          cnt_d   = total_q;
          ov_d    = drop_q;
          fill_d  = '0;
          drop_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      drop_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    v_q     <= v_d;
    j_q     <= j_d;
    l_q     <= l_d;
    r_q     <= r_d;
    total_q <= total_d;
    ov_q    <= ov_d;
    cnt_q   <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa[AW-1:0]] <= wd;
    end
    rda_q <= mem[ra[AW-1:0]];
    rdb_q <= mem[rb[AW-1:0]];
  end

endmodule

// ===== src/count_pairs_within_radius_top.sv =====
// Close-pair counter for a batch of 1-D points.
// Input channel: one point word per accepted cycle (in_valid_i high, in_stall_o
// low); last_i marks the final point of the batch. A two-word queue takes
// words while the back end works.
// Each point is placed into a sorted store by insertion: every stored point
// larger than it is shifted up one slot, at most MAX_POINTS - 1 of them.
// On the last word the store is scanned with a sliding left edge that moves
// up while the gap to the right edge reaches radius; the back end takes the
// next point only when the insertion shift loop on the single-write store ends.
// Output channel: one word with pair_count_o and overflow_o per batch, held
// in a register until accepted (out_valid_o high, out_stall_i low). While
// the receiver stalls, the next batch keeps loading and only the count end
// waits.
// Points beyond MAX_POINTS are dropped and flagged in overflow_o.
// radius is written through the APB port at address 0; the user must write it
// only while idle, as the block does not enforce this. Reset empties the
// queue and the store and clears radius; there is no clearing pass.
module count_pairs_within_radius_top
  import cpwr_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [PointW-1:0] point_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CountW-1:0] pair_count_o,
  output logic              overflow_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [RadiusW-1:0] radius_q;
  logic               q_valid;
  item_t              q_item;
  logic               q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrRadius) ? radius_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (psel && penable && pwrite && paddr == AddrRadius) begin
      radius_q <= pwdata;
    end
  end

  cpwr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .point_i   (point_i),
    .last_i    (last_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  cpwr_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radius_i    (radius_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pair_count_o(pair_count_o),
    .overflow_o  (overflow_o)
  );

endmodule

// ===== src/cpwr_checker.sv =====
`include "count_pairs_within_radius_top_macros.svh"

module cpwr_checker
  import cpwr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CountW-1:0] pair_count_o,
  input logic              overflow_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [2:0]        paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);

  `CPWR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")
  `CPWR_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(pair_count_o) && $stable(overflow_o), "result changed under stall")
  `CPWR_ASSERT(a_pready, pready, "pready low")
  `CPWR_ASSERT_NEXT(a_radius_rd, psel && penable && pwrite && paddr == AddrRadius, paddr != AddrRadius || prdata == $past(pwdata), "radius readback mismatch")

endmodule

bind count_pairs_within_radius_top cpwr_checker u_cpwr_checker (.*);
